FILE: sv/flha_pkg.sv
// ----------------------------------------------------------------------------
// flha_pkg
// Shared codes and types of the free-list heap allocator.
// ----------------------------------------------------------------------------
package flha_pkg;

  // Field widths of the stream beats
  localparam int unsigned REQ_BYTES_W = 11;
  localparam int unsigned OFFSET_W    = 10;
  localparam int unsigned GRANT_W     = 11;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POLICY_W    = 2;
  localparam int unsigned IN_DATA_W   = 24;
  localparam int unsigned OUT_DATA_W  = 24;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_ALLOC = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OOM   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FREED = 2'd2;

  // Search policies; the unused code acts as first fit
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_NEXT  = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FSIZE,
    ST_WALK,
    ST_WR1,
    ST_WR2,
    ST_RESP
  } flha_state_e;

endpackage

FILE: sv/free_list_heap_allocator_unit.sv
// ----------------------------------------------------------------------------
// free_list_heap_allocator_unit
// Address-ordered free-list allocator over a byte pool (first, best, next fit).
// ----------------------------------------------------------------------------
// Each input beat is one request and yields exactly one result beat. The free
// list lives in two synchronous memories (block size and next link, indexed by
// block offset) and each allocate or valid free on a non-empty list walks the
// list from its head, one header per cycle through the single read port. An
// allocate walks the whole list; a free stops at the first block that is not
// below the released one, or at the list end. A rejected free (bad offset)
// skips the walk. Input beats are taken while a result beat still waits at the
// output. After reset the block sweeps both memories once, one entry per
// cycle; s_axis_tready stays low during the sweep while configuration writes
// are still taken. Write fit_policy only while no request is in flight.
module free_list_heap_allocator_unit #(
  parameter int unsigned POOL_BYTES      = 1024,
  parameter int unsigned FREE_HDR_BYTES  = 16,
  parameter int unsigned ALLOC_HDR_BYTES = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: [10:0] request_bytes, [20:11] release_offset, [23:21] zero
  input  logic [flha_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // tuser: [0] req_type
  input  logic                               s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: [9:0] user_offset, [20:10] granted_bytes, [23:21] zero
  output logic [flha_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // tuser: [1:0] status
  output logic [flha_pkg::STATUS_W-1:0]      m_axis_tuser,
  // policy register write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [flha_pkg::POLICY_W-1:0]      cfg_data_i
);

  import flha_pkg::*;

  localparam int unsigned IW = $clog2(POOL_BYTES);
  localparam int unsigned LW = $clog2(POOL_BYTES + 1);
  localparam int unsigned XW = ((LW > REQ_BYTES_W) ? LW : REQ_BYTES_W) + 2;

  localparam logic [LW-1:0] NIL       = LW'(POOL_BYTES);
  localparam logic [LW-1:0] SIZE_MAX  = LW'(POOL_BYTES);
  localparam logic [XW-1:0] POOL_X    = XW'(POOL_BYTES);
  localparam logic [XW-1:0] AH_X      = XW'(ALLOC_HDR_BYTES);
  localparam logic [XW-1:0] FH_X      = XW'(FREE_HDR_BYTES);
  localparam logic [IW-1:0] LAST_ADDR = IW'(POOL_BYTES - 1);

  function automatic logic [LW-1:0] sat_size(input logic [XW-1:0] v);
    sat_size = (v > POOL_X) ? SIZE_MAX : v[LW-1:0];
  endfunction

  function automatic logic [LW-1:0] clean_link(input logic [XW-1:0] v);
    clean_link = (v >= POOL_X) ? NIL : v[LW-1:0];
  endfunction

  // Walk successor: the link only counts when it points higher and in range
  function automatic logic [LW-1:0] succ(input logic [IW-1:0] x, input logic [LW-1:0] l);
    succ = (l < NIL && l > LW'(x)) ? l : NIL;
  endfunction

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  flha_state_e state_q, state_d;
  logic [POLICY_W-1:0] policy_q;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] rover_q, rover_d;
  logic [IW-1:0] clr_q, clr_d;

  // request context
  logic          free_q, free_d;
  logic [XW-1:0] need_q, need_d;
  logic [IW-1:0] h_q, h_d;
  logic [LW-1:0] fs_q, fs_d;
  logic          ok_q, ok_d;
  logic [IW-1:0] cur_q, cur_d;
  logic [IW-1:0] prev_q, prev_d;
  logic          hp_q, hp_d;
  logic [LW-1:0] prev_sz_q, prev_sz_d;
  logic          seen_q, seen_d;
  // free insertion point
  logic [LW-1:0] nxt_q, nxt_d;
  logic [LW-1:0] nxt_sz_q, nxt_sz_d;
  logic [LW-1:0] nn_q, nn_d;
  // first-fit candidate and the policy candidate (best or past the rover)
  logic          ff_found_q, ff_found_d;
  logic [IW-1:0] ff_a_q, ff_a_d, ff_prev_q, ff_prev_d;
  logic [LW-1:0] ff_sz_q, ff_sz_d, ff_nxt_q, ff_nxt_d;
  logic          ff_hp_q, ff_hp_d;
  logic          alt_found_q, alt_found_d;
  logic [IW-1:0] alt_a_q, alt_a_d, alt_prev_q, alt_prev_d;
  logic [LW-1:0] alt_sz_q, alt_sz_d, alt_nxt_q, alt_nxt_d;
  logic          alt_hp_q, alt_hp_d;
  // result register
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [OFFSET_W-1:0] out_off_q, out_off_d;
  logic [GRANT_W-1:0]  out_grant_q, out_grant_d;

  // memory port
  logic [IW-1:0] rd_addr;
  logic [LW-1:0] rd_size, rd_link;
  logic          sz_we, lk_we;
  logic [IW-1:0] sz_waddr, lk_waddr;
  logic [LW-1:0] sz_wdata, lk_wdata;

  flha_store #(
    .DEPTH (POOL_BYTES),
    .AW    (IW),
    .DW    (LW)
  ) u_store (
    .clk_i      (clk_i),
    .rd_addr_i  (rd_addr),
    .rd_size_o  (rd_size),
    .rd_link_o  (rd_link),
    .sz_we_i    (sz_we),
    .sz_waddr_i (sz_waddr),
    .sz_wdata_i (sz_wdata),
    .lk_we_i    (lk_we),
    .lk_waddr_i (lk_waddr),
    .lk_wdata_i (lk_wdata)
  );

  // --------------------------------------------------------------------------
  // Input beat fields
  // --------------------------------------------------------------------------
  logic [REQ_BYTES_W-1:0] in_req_bytes;
  logic [OFFSET_W-1:0]    in_rel;
  logic [XW-1:0]          rel_x, h_x;
  logic                   rel_bad;

  assign in_req_bytes = s_axis_tdata[REQ_BYTES_W-1:0];
  assign in_rel       = s_axis_tdata[REQ_BYTES_W +: OFFSET_W];
  assign rel_x        = XW'(in_rel);
  assign h_x          = rel_x - AH_X;
  assign rel_bad      = (rel_x < AH_X) || (h_x >= POOL_X);

  // --------------------------------------------------------------------------
  // Walk step on the node whose header just came back
  // --------------------------------------------------------------------------
  logic [LW-1:0] walk_nx;
  logic          fits, at_rover;

  assign walk_nx  = succ(cur_q, rd_link);
  assign fits     = XW'(rd_size) >= need_q;
  assign at_rover = seen_q || (LW'(cur_q) == rover_q);

  // --------------------------------------------------------------------------
  // Chosen allocate candidate and its split
  // --------------------------------------------------------------------------
  logic          use_alt;
  logic [IW-1:0] p_a, p_prev;
  logic [LW-1:0] p_sz, p_nxt;
  logic          p_hp;
  logic [XW-1:0] rem_x, nf_x, off_x, grant_x;
  logic          split, nf_ok;
  logic [LW-1:0] alloc_target;

  assign use_alt = (policy_q == POLICY_BEST) || ((policy_q == POLICY_NEXT) && alt_found_q);
  assign p_a     = use_alt ? alt_a_q    : ff_a_q;
  assign p_prev  = use_alt ? alt_prev_q : ff_prev_q;
  assign p_sz    = use_alt ? alt_sz_q   : ff_sz_q;
  assign p_nxt   = use_alt ? alt_nxt_q  : ff_nxt_q;
  assign p_hp    = use_alt ? alt_hp_q   : ff_hp_q;

  assign rem_x   = XW'(p_sz) - need_q;
  assign split   = (rem_x > FH_X) && (rem_x > AH_X);
  assign nf_x    = XW'(p_a) + need_q;
  assign nf_ok   = nf_x < POOL_X;
  assign off_x   = XW'(p_a) + AH_X;
  assign grant_x = split ? need_q : XW'(p_sz);
  assign alloc_target = split ? clean_link(nf_x) : p_nxt;

  // --------------------------------------------------------------------------
  // Free merge decision
  // --------------------------------------------------------------------------
  logic          left, right;
  logic [XW-1:0] left_sum;

  assign left  = hp_q && ((XW'(prev_q) + XW'(prev_sz_q)) == XW'(h_q));
  assign right = (nxt_q != NIL) && ((XW'(h_q) + XW'(fs_q)) == XW'(nxt_q));
  assign left_sum = XW'(prev_sz_q) + XW'(fs_q) + (right ? XW'(nxt_sz_q) : XW'(0));

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    rover_d     = rover_q;
    clr_d       = clr_q;
    free_d      = free_q;
    need_d      = need_q;
    h_d         = h_q;
    fs_d        = fs_q;
    ok_d        = ok_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    hp_d        = hp_q;
    prev_sz_d   = prev_sz_q;
    seen_d      = seen_q;
    nxt_d       = nxt_q;
    nxt_sz_d    = nxt_sz_q;
    nn_d        = nn_q;
    ff_found_d  = ff_found_q;
    ff_a_d      = ff_a_q;
    ff_prev_d   = ff_prev_q;
    ff_sz_d     = ff_sz_q;
    ff_nxt_d    = ff_nxt_q;
    ff_hp_d     = ff_hp_q;
    alt_found_d = alt_found_q;
    alt_a_d     = alt_a_q;
    alt_prev_d  = alt_prev_q;
    alt_sz_d    = alt_sz_q;
    alt_nxt_d   = alt_nxt_q;
    alt_hp_d    = alt_hp_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_status_d = out_status_q;
    out_off_d    = out_off_q;
    out_grant_d  = out_grant_q;

    rd_addr  = cur_q;
    sz_we    = 1'b0;
    sz_waddr = h_q;
    sz_wdata = fs_q;
    lk_we    = 1'b0;
    lk_waddr = h_q;
    lk_wdata = nxt_q;
    s_axis_tready = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep: every entry zero, entry zero holds the whole pool
        sz_we    = 1'b1;
        sz_waddr = clr_q;
        sz_wdata = (clr_q == '0) ? SIZE_MAX : '0;
        lk_we    = 1'b1;
        lk_waddr = clr_q;
        lk_wdata = (clr_q == '0) ? NIL : '0;
        clr_d    = clr_q + 1'b1;
        if (clr_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          free_d      = (s_axis_tuser == REQ_FREE);
          need_d      = XW'(in_req_bytes) + AH_X;
          h_d         = IW'(h_x);
          ok_d        = 1'b0;
          hp_d        = 1'b0;
          seen_d      = 1'b0;
          ff_found_d  = 1'b0;
          alt_found_d = 1'b0;
          nxt_d       = NIL;
          nn_d        = NIL;
          cur_d       = IW'(head_q);
          if (s_axis_tuser == REQ_FREE) begin
            if (rel_bad) begin
              state_d = ST_RESP;
            end else begin
              rd_addr = IW'(h_x);
              state_d = ST_FSIZE;
            end
          end else if (head_q == NIL) begin
            state_d = ST_RESP;
          end else begin
            rd_addr = IW'(head_q);
            state_d = ST_WALK;
          end
        end
      end

      ST_FSIZE: begin
        fs_d = rd_size;
        ok_d = 1'b1;
        if (head_q == NIL) begin
          state_d = ST_WR1;
        end else begin
          rd_addr = IW'(head_q);
          state_d = ST_WALK;
        end
      end

      ST_WALK: begin
        if (free_q) begin
          priority if (cur_q == h_q) begin
            // already on the list: drop the request
            ok_d    = 1'b0;
            state_d = ST_RESP;
          end else if (cur_q < h_q) begin
            prev_d    = cur_q;
            prev_sz_d = rd_size;
            hp_d      = 1'b1;
            if (walk_nx == NIL) begin
              state_d = ST_WR1;
            end else begin
              rd_addr = IW'(walk_nx);
              cur_d   = IW'(walk_nx);
            end
          end else begin
            nxt_d    = LW'(cur_q);
            nxt_sz_d = rd_size;
            nn_d     = walk_nx;
            state_d  = ST_WR1;
          end
        end else begin
          if (fits && !ff_found_q) begin
            ff_found_d = 1'b1;
            ff_a_d     = cur_q;
            ff_sz_d    = rd_size;
            ff_prev_d  = prev_q;
            ff_hp_d    = hp_q;
            ff_nxt_d   = walk_nx;
          end
          if (fits && (((policy_q == POLICY_BEST) && (!alt_found_q || rd_size < alt_sz_q)) ||
                       ((policy_q == POLICY_NEXT) && !alt_found_q && at_rover))) begin
            alt_found_d = 1'b1;
            alt_a_d     = cur_q;
            alt_sz_d    = rd_size;
            alt_prev_d  = prev_q;
            alt_hp_d    = hp_q;
            alt_nxt_d   = walk_nx;
          end
          seen_d = at_rover;
          prev_d = cur_q;
          hp_d   = 1'b1;
          if (walk_nx == NIL) begin
            ok_d    = ff_found_d;
            state_d = ff_found_d ? ST_WR1 : ST_RESP;
          end else begin
            rd_addr = IW'(walk_nx);
            cur_d   = IW'(walk_nx);
          end
        end
      end

      ST_WR1: begin
        if (free_q) begin
          priority if (left) begin
            sz_we    = 1'b1;
            sz_waddr = prev_q;
            sz_wdata = sat_size(left_sum);
            lk_we    = right;
            lk_waddr = prev_q;
            lk_wdata = nn_q;
          end else if (right) begin
            sz_we    = 1'b1;
            sz_wdata = sat_size(XW'(fs_q) + XW'(nxt_sz_q));
            lk_we    = 1'b1;
            lk_wdata = nn_q;
          end else begin
            sz_we    = 1'b1;
            sz_wdata = fs_q;
            lk_we    = 1'b1;
            lk_wdata = nxt_q;
          end
          // right neighbor merged away: move the rover to the merged block
          if (right && rover_q == nxt_q) begin
            rover_d = left ? LW'(prev_q) : LW'(h_q);
          end
        end else if (split && nf_ok) begin
          sz_we    = 1'b1;
          sz_waddr = IW'(nf_x);
          sz_wdata = sat_size(rem_x);
          lk_we    = 1'b1;
          lk_waddr = IW'(nf_x);
          lk_wdata = p_nxt;
        end
        state_d = ST_WR2;
      end

      ST_WR2: begin
        if (free_q) begin
          if (!left) begin
            if (hp_q) begin
              lk_we    = 1'b1;
              lk_waddr = prev_q;
              lk_wdata = LW'(h_q);
            end else begin
              head_d = LW'(h_q);
            end
          end
        end else begin
          sz_we    = split;
          sz_waddr = p_a;
          sz_wdata = sat_size(need_q);
          if (p_hp) begin
            lk_we    = 1'b1;
            lk_waddr = p_prev;
            lk_wdata = alloc_target;
          end else begin
            head_d = alloc_target;
          end
          rover_d = alloc_target;
        end
        state_d = ST_RESP;
      end

      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (free_q) begin
            out_status_d = STATUS_FREED;
            out_off_d    = '0;
            out_grant_d  = '0;
          end else if (ok_q) begin
            out_status_d = STATUS_ALLOC;
            out_off_d    = off_x[OFFSET_W-1:0];
            out_grant_d  = grant_x[GRANT_W-1:0];
          end else begin
            out_status_d = STATUS_OOM;
            out_off_d    = '0;
            out_grant_d  = '0;
          end
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      policy_q    <= POLICY_FIRST;
      head_q      <= '0;
      rover_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      head_q      <= head_d;
      rover_q     <= rover_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        policy_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    free_q       <= free_d;
    need_q       <= need_d;
    h_q          <= h_d;
    fs_q         <= fs_d;
    ok_q         <= ok_d;
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    hp_q         <= hp_d;
    prev_sz_q    <= prev_sz_d;
    seen_q       <= seen_d;
    nxt_q        <= nxt_d;
    nxt_sz_q     <= nxt_sz_d;
    nn_q         <= nn_d;
    ff_found_q   <= ff_found_d;
    ff_a_q       <= ff_a_d;
    ff_prev_q    <= ff_prev_d;
    ff_sz_q      <= ff_sz_d;
    ff_nxt_q     <= ff_nxt_d;
    ff_hp_q      <= ff_hp_d;
    alt_found_q  <= alt_found_d;
    alt_a_q      <= alt_a_d;
    alt_prev_q   <= alt_prev_d;
    alt_sz_q     <= alt_sz_d;
    alt_nxt_q    <= alt_nxt_d;
    alt_hp_q     <= alt_hp_d;
    out_status_q <= out_status_d;
    out_off_q    <= out_off_d;
    out_grant_q  <= out_grant_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - OFFSET_W - GRANT_W){1'b0}}, out_grant_q, out_off_q};

endmodule

FILE: sv/flha_store.sv
// ----------------------------------------------------------------------------
// flha_store
// Block-size and link memories: one shared read address, registered read
// data, an independent write port for each memory.
// ----------------------------------------------------------------------------
module flha_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 11
) (
  input  logic          clk_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_size_o,
  output logic [DW-1:0] rd_link_o,
  input  logic          sz_we_i,
  input  logic [AW-1:0] sz_waddr_i,
  input  logic [DW-1:0] sz_wdata_i,
  input  logic          lk_we_i,
  input  logic [AW-1:0] lk_waddr_i,
  input  logic [DW-1:0] lk_wdata_i
);

  logic [DW-1:0] size_mem [DEPTH];
  logic [DW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (sz_we_i) begin
      size_mem[sz_waddr_i] <= sz_wdata_i;
    end
    rd_size_o <= size_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (lk_we_i) begin
      link_mem[lk_waddr_i] <= lk_wdata_i;
    end
    rd_link_o <= link_mem[rd_addr_i];
  end

endmodule
